FILE: hdl/lzd_pkg.sv
`timescale 1ns / 1ps

package lzd_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned DistW = 15;
  localparam int unsigned CodeW = 4;
  localparam int unsigned LenW  = 5;

  // history window; a power of two so the write pointer wraps by itself
  localparam int unsigned WindowDepth = 32768;
  localparam int unsigned WinAddrW    = 15;

  // match length range
  localparam logic [LenW-1:0] MinMatch = 5'd3;
  localparam logic [LenW-1:0] MaxMatch = 5'd18;

  // token mode codes on the input channel
  localparam logic [1:0] ModeLit   = 2'd0;
  localparam logic [1:0] ModeMatch = 2'd1;
  localparam logic [1:0] ModeEnd   = 2'd2;

  // command queue between front and back
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned CmdCntW  = 2;

  // result queue
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = 2;
  localparam int unsigned ResLvlW  = 3;

  // configuration register map: word index taken from paddr[2]
  localparam int unsigned PaddrW        = 3;
  localparam logic        RegExpectedSz = 1'b0;

  typedef enum logic [1:0] {
    KindLit   = 2'd0,
    KindMatch = 2'd1,
    KindEnd   = 2'd2
  } lzd_kind_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [DataW-1:0] literal_byte;
    logic [DistW-1:0] distance;
    logic [CodeW-1:0] length_code;
  } lzd_item_t;

  typedef struct packed {
    logic [DataW-1:0] out_byte;
    logic             last_of_run;
    logic             end_seen;
  } lzd_result_t;

  typedef struct packed {
    lzd_kind_e        kind;
    logic [DataW-1:0] lit;
    logic [DistW-1:0] reach;
    logic [LenW-1:0]  len;
  } lzd_cmd_t;

endpackage

FILE: hdl/lzd_front.sv
`timescale 1ns / 1ps

module lzd_front import lzd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  lzd_item_t item_i,
  output lzd_cmd_t  cmd_o,
  output logic      cmd_vld_o,
  input  logic      cmd_pop_i
);

  lzd_cmd_t             buf_q [CmdDepth];
  logic [CmdCntW-1:0]   cnt_q, cnt_d;
  logic                 wr_q, rd_q;
  logic                 stopped_q, stopped_d;
  logic                 accept, keep, enq, deq;
  lzd_cmd_t             cmd_new;
  logic [LenW-1:0]      len_raw;

  assign full      = (cnt_q == CmdCntW'(CmdDepth));
  assign accept    = push && !full;
  assign cmd_vld_o = (cnt_q != '0);
  assign cmd_o     = buf_q[rd_q];
  assign deq       = cmd_pop_i && cmd_vld_o;

  // classify the token; saturate the copy length
  always_comb begin
    len_raw       = LenW'(item_i.length_code) + MinMatch;
    cmd_new.lit   = item_i.literal_byte;
    cmd_new.reach = item_i.distance;
    cmd_new.len   = (len_raw > MaxMatch) ? MaxMatch : len_raw;
    cmd_new.kind  = KindLit;
    keep          = 1'b1;
    case (item_i.mode)
      ModeLit:   cmd_new.kind = KindLit;
      ModeMatch: cmd_new.kind = KindMatch;
      ModeEnd:   cmd_new.kind = KindEnd;
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // everything after the end token is swallowed here
  assign enq       = accept && !stopped_q && keep;
  assign stopped_d = stopped_q || (accept && item_i.mode == ModeEnd);
  assign cnt_d     = cnt_q + CmdCntW'(enq) - CmdCntW'(deq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      wr_q      <= 1'b0;
      rd_q      <= 1'b0;
      stopped_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      stopped_q <= stopped_d;
      if (enq) begin
        wr_q <= ~wr_q;
      end
      if (deq) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      buf_q[wr_q] <= cmd_new;
    end
  end

endmodule

FILE: hdl/lzd_back.sv
`timescale 1ns / 1ps

module lzd_back import lzd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lzd_cmd_t           cmd_i,
  input  logic               cmd_vld_i,
  output logic               cmd_pop_o,
  input  logic [31:0]        byte_limit_i,
  input  logic [ResLvlW-1:0] lvl_i,
  output logic               res_push_o,
  output lzd_result_t        res_o
);

  localparam int unsigned AW = WinAddrW;

  logic [DataW-1:0] win_mem [WindowDepth];
  logic [DataW-1:0] rdata_q;

  // sequencer state
  logic             busy_q, busy_d;
  logic [LenW-1:0]  rem_q, rem_d, rem;
  logic [AW-1:0]    ip_q;
  logic             ip_wrap_q;
  logic [31:0]      bytes_q;

  // write/emit stage
  logic             w_vld_q;
  logic             w_lit_q, w_end_q, w_last_q;
  logic [DataW-1:0] w_lbyte_q, w_bypd_q;
  logic [AW-1:0]    w_addr_q;
  logic             w_byp_q, w_known_q;
  logic [DataW-1:0] w_byte;
  logic             w_we;

  logic             lim, at_end, room;
  logic             iss, iss_lit, iss_end, iss_byte, last, pop;
  logic [AW-1:0]    raddr;

  assign rem    = busy_q ? rem_q : cmd_i.len;
  assign lim    = (bytes_q >= byte_limit_i);
  assign at_end = ((bytes_q + 32'd1) == byte_limit_i);
  // room counts the byte still in flight
  assign room   = (lvl_i + ResLvlW'(w_vld_q)) < ResLvlW'(ResDepth);
  assign raddr  = ip_q - AW'(cmd_i.reach);

  always_comb begin
    iss     = 1'b0;
    iss_lit = 1'b0;
    iss_end = 1'b0;
    last    = 1'b0;
    pop     = 1'b0;
    busy_d  = busy_q;
    rem_d   = rem_q;
    if (cmd_vld_i) begin
      case (cmd_i.kind)
        KindEnd: begin
          if (room) begin
            iss     = 1'b1;
            iss_end = 1'b1;
            last    = 1'b1;
            pop     = 1'b1;
          end
        end
        KindLit: begin
          if (lim) begin
            pop = 1'b1;
          end else if (room) begin
            iss     = 1'b1;
            iss_lit = 1'b1;
            last    = 1'b1;
            pop     = 1'b1;
          end
        end
        KindMatch: begin
          if (lim) begin
            pop    = 1'b1;
            busy_d = 1'b0;
          end else if (room) begin
            iss  = 1'b1;
            last = (rem == LenW'(1)) || at_end;
            if (last) begin
              pop    = 1'b1;
              busy_d = 1'b0;
            end else begin
              busy_d = 1'b1;
              rem_d  = rem - LenW'(1);
            end
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  assign cmd_pop_o = pop;
  assign iss_byte  = iss && !iss_end;

  // emit-stage byte: literal, forwarded, stored, or zero for end or unwritten slot
  always_comb begin
    if (w_lit_q) begin
      w_byte = w_lbyte_q;
    end else if (w_end_q) begin
      w_byte = '0;
    end else if (w_byp_q) begin
      w_byte = w_bypd_q;
    end else if (w_known_q) begin
      w_byte = rdata_q;
    end else begin
      w_byte = '0;
    end
  end

  assign w_we = w_vld_q && !w_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      rem_q     <= '0;
      ip_q      <= '0;
      ip_wrap_q <= 1'b0;
      bytes_q   <= '0;
      w_vld_q   <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      rem_q   <= rem_d;
      w_vld_q <= iss;
      if (iss_byte) begin
        bytes_q <= bytes_q + 32'd1;
        ip_q    <= ip_q + AW'(1);
        if (ip_q == '1) begin
          ip_wrap_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (iss) begin
      w_lit_q   <= iss_lit;
      w_end_q   <= iss_end;
      w_last_q  <= last;
      w_lbyte_q <= cmd_i.lit;
      w_addr_q  <= ip_q;
      // slot being written this cycle is not in the array yet
      w_byp_q   <= w_we && (w_addr_q == raddr);
      w_bypd_q  <= w_byte;
      w_known_q <= ip_wrap_q || (raddr < ip_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      win_mem[w_addr_q] <= w_byte;
    end
    rdata_q <= win_mem[raddr];
  end

  assign res_push_o        = w_vld_q;
  assign res_o.out_byte    = w_byte;
  assign res_o.last_of_run = w_last_q;
  assign res_o.end_seen    = w_end_q;

endmodule

FILE: hdl/lzd_res_queue.sv
`timescale 1ns / 1ps

module lzd_res_queue import lzd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lzd_result_t        data_i,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [ResLvlW-1:0] level_o,
  output lzd_result_t        data_o
);

  lzd_result_t          mem_q [ResDepth];
  logic [ResPtrW-1:0]   wr_q, rd_q;
  logic [ResLvlW-1:0]   cnt_q;
  logic                 deq;

  assign empty_o = (cnt_q == '0);
  assign level_o = cnt_q;
  assign data_o  = mem_q[rd_q];
  assign deq     = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + ResLvlW'(push_i) - ResLvlW'(deq);
      if (push_i) begin
        wr_q <= wr_q + ResPtrW'(1);
      end
      if (deq) begin
        rd_q <= rd_q + ResPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: hdl/lz77_window_decoder_core.sv
`timescale 1ns / 1ps

// Channel   Ports                              Moves
// --------  ---------------------------------  ---------------------------------
// token in  push, full, item_i                 one LZ77 token per request
// result    empty, pop, result_o               one output byte or end mark
// config    psel, penable, pwrite, paddr,      output byte limit at word 0
//           pwdata, prdata, pready
//
// The back end issues a literal or end token whole and a match one copied byte
// at a time (3 to 18), as the window memory has a single read port. With
// nothing ahead, a token passes the command queue, the write/emit stage and
// the result queue before its result reaches the result ports. The window is
// never swept: slots not yet written since reset read as zero through the fill
// tracking, so the block takes tokens right after reset. A full result queue
// stalls the back end only; the front keeps filling its two-entry command queue.

module lz77_window_decoder_core import lzd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // token channel
  input  logic              push,
  output logic              full,
  input  lzd_item_t         item_i,
  // result channel
  output logic              empty,
  input  logic              pop,
  output lzd_result_t       result_o,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [31:0]        exp_size_q;
  logic               cfg_wr;

  lzd_cmd_t           cmd;
  logic               cmd_vld, cmd_pop;
  logic               res_push;
  lzd_result_t        res;
  logic [ResLvlW-1:0] res_lvl;

  // config register; user writes it only while the datapath is idle (unchecked)
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegExpectedSz);
  assign prdata = (paddr[2] == RegExpectedSz) ? exp_size_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_size_q <= '0;
    end else if (cfg_wr) begin
      exp_size_q <= pwdata;
    end
  end

  // front: takes token requests, drops unused modes and anything after end
  lzd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .item_i    (item_i),
    .cmd_o     (cmd),
    .cmd_vld_o (cmd_vld),
    .cmd_pop_i (cmd_pop)
  );

  // back: size limit, window reads and writes, one byte a cycle unless stalled
  lzd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cmd_vld_i    (cmd_vld),
    .cmd_pop_o    (cmd_pop),
    .byte_limit_i (exp_size_q),
    .lvl_i        (res_lvl),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  // result queue decouples the back end from the consumer
  lzd_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .pop_i   (pop),
    .empty_o (empty),
    .level_o (res_lvl),
    .data_o  (result_o)
  );

endmodule

FILE: tb/lz77_window_decoder_core_test.sv
`timescale 1ns / 1ps

// Token stream against a cycle-free predictor of the window decoder.
// Tokens are queued by the stimulus block, driven by a gap-inserting driver,
// and every request taken on the token side is decoded at once into the bytes
// it should produce; the result side pops at random and checks in order.

module lz77_window_decoder_core_test;
  import lzd_pkg::*;

  localparam int unsigned WinDepth    = 32768;
  localparam logic [1:0]  ModeSpare   = 2'd3;  // undefined token kind, dropped by the block
  localparam logic [PaddrW-1:0] SizeAddr = {RegExpectedSz, 2'b00};
  localparam int unsigned StallLimit  = 2000;  // cycles with no request moving
  localparam int unsigned DrainCycles = 64;    // two queued 18-byte copies plus pipeline
  localparam int unsigned ShowErrs    = 10;

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              push    = 1'b0;
  logic              full;
  lzd_item_t         item_i  = '0;
  logic              empty;
  logic              pop     = 1'b0;
  lzd_result_t       result_o;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [PaddrW-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  lz77_window_decoder_core uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Decoder state mirror: window, write pointer, byte count, end flag, limit
  // ---------------------------------------------------------------------------
  bit [DataW-1:0] hist_mem [WinDepth];
  bit [DistW-1:0] wr_ptr;
  bit [31:0]      produced;
  bit             halted;
  bit [31:0]      size_limit;

  lzd_item_t   token_q[$];    // tokens waiting for the driver
  lzd_result_t decoded_q[$];  // bytes and end marks owed by the block

  int unsigned send_gap_pct, pop_gap_pct;
  int unsigned tokens_taken, results_seen, err_cnt, stall_cnt;
  bit          tok_fire, res_fire;
  lzd_result_t want;

  function automatic void keep_byte(logic [DataW-1:0] b);
    hist_mem[wr_ptr] = b;
    wr_ptr++;
    produced++;
  endfunction

  // Work out everything one accepted token should produce.
  function automatic void decode_token(lzd_item_t t);
    int unsigned    run_len;
    int unsigned    k;
    logic [DistW-1:0] rd;
    lzd_result_t    r;
    if (halted) return;
    r = '0;
    case (t.mode)
      ModeLit: begin
        if (produced < size_limit) begin
          keep_byte(t.literal_byte);
          r.out_byte    = t.literal_byte;
          r.last_of_run = 1'b1;
          decoded_q.push_back(r);
        end
      end
      ModeMatch: begin
        run_len = t.length_code + MinMatch;
        if (run_len > MaxMatch) run_len = MaxMatch;
        for (k = 0; k < run_len; k++) begin
          if (produced >= size_limit) break;
          // distance is taken modulo the window, so the 15-bit wrap does it
          rd = wr_ptr - t.distance;
          r.out_byte = hist_mem[rd];
          keep_byte(r.out_byte);
          // a copy cut short at the limit marks its last byte too
          r.last_of_run = (k == run_len - 1) || (produced >= size_limit);
          decoded_q.push_back(r);
        end
      end
      ModeEnd: begin
        halted        = 1'b1;
        r.last_of_run = 1'b1;
        r.end_seen    = 1'b1;
        decoded_q.push_back(r);
      end
      default: ;  // spare kind: nothing happens
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sampling at the rising edge: token requests feed the predictor, result
  // requests are checked against the oldest owed entry, and a watchdog ends
  // the run if nothing moves for too long.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tok_fire = 1'b0;
    res_fire = 1'b0;
    if (rst_ni) begin
      if (push && !full) begin
        tok_fire = 1'b1;
        decode_token(item_i);
        token_q.delete(0);
        tokens_taken++;
      end
      if (!empty && pop) begin
        res_fire = 1'b1;
        results_seen++;
        if (decoded_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= ShowErrs)
            $display("%0t: result with nothing owed: byte %02h last %b end %b", $time,
                     result_o.out_byte, result_o.last_of_run, result_o.end_seen);
        end else begin
          want = decoded_q.pop_front();
          if (result_o.out_byte !== want.out_byte ||
              result_o.last_of_run !== want.last_of_run ||
              result_o.end_seen !== want.end_seen) begin
            err_cnt++;
            if (err_cnt <= ShowErrs)
              $display("%0t: result %0d expected byte %02h last %b end %b, got %02h %b %b",
                       $time, results_seen, want.out_byte, want.last_of_run,
                       want.end_seen, result_o.out_byte, result_o.last_of_run,
                       result_o.end_seen);
          end
        end
      end
      if (tok_fire || res_fire) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= StallLimit) begin
        $display("%0t: stuck, %0d tokens queued, %0d results owed", $time,
                 token_q.size(), decoded_q.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving at the falling edge. A token stays on the port until it is taken;
  // a new one is offered only after the previous request went through.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!push || tok_fire) begin
      if (token_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        push   <= 1'b1;
        item_i <= token_q[0];
      end else begin
        push <= 1'b0;
      end
    end
    pop <= ($urandom_range(99) >= pop_gap_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_token(logic [1:0] m, logic [DataW-1:0] lit,
                                    logic [DistW-1:0] d, logic [CodeW-1:0] c);
    lzd_item_t t;
    t.mode         = m;
    t.literal_byte = lit;
    t.distance     = d;
    t.length_code  = c;
    token_q.push_back(t);
  endfunction

  // Mostly literals and copies; distances lean on very short (overlapping,
  // zero) and very long reaches, the rest spread over the window.
  function automatic void fill_random(int unsigned n);
    int unsigned      pick;
    logic [1:0]       m;
    logic [DistW-1:0] d;
    repeat (n) begin
      pick = $urandom_range(99);
      m = (pick < 45) ? ModeLit : (pick < 93) ? ModeMatch : ModeSpare;
      case ($urandom_range(3))
        0:       d = DistW'($urandom_range(8));
        1:       d = DistW'($urandom_range(32767, 32760));
        default: d = DistW'($urandom);
      endcase
      add_token(m, DataW'($urandom), d, CodeW'($urandom));
    end
  endfunction

  // Sender holds off until every owed result is out, then lets a cut-short or
  // silent copy finish inside the block.
  task automatic wait_drained();
    while (token_q.size() != 0 || decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write the output byte limit, then read it back.
  task automatic write_size(input logic [31:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SizeAddr;
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    size_limit = v;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== v) begin
      err_cnt++;
      if (err_cnt <= ShowErrs)
        $display("%0t: size limit reads %08h, expected %08h", $time, prdata, v);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    send_gap_pct = 32;
    pop_gap_pct  = 74;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero limit: tokens go in, nothing comes out
    write_size(32'd0);
    add_token(ModeLit, 8'h3C, 15'd0, 4'd0);
    add_token(ModeMatch, 8'h00, 15'd1, 4'd15);
    add_token(ModeLit, 8'hFF, 15'd0, 4'd0);
    wait_drained();

    // no limit: literals, overlapping copies, reaches into untouched slots
    write_size(32'hFFFF_FFFF);
    add_token(ModeLit, 8'h00, 15'd0, 4'd0);
    add_token(ModeLit, 8'hFF, 15'd0, 4'd0);
    add_token(ModeLit, 8'hA5, 15'd0, 4'd0);
    add_token(ModeMatch, 8'h00, 15'd1, 4'd0);          // repeats the last byte
    add_token(ModeMatch, 8'h00, 15'd0, 4'd15);         // slot at the pointer, unwritten
    add_token(ModeMatch, 8'h00, 15'd32767, 4'd15);     // farthest reach
    add_token(ModeLit, 8'h5A, 15'd0, 4'd0);
    add_token(ModeMatch, 8'h00, 15'd4, 4'd7);          // period-4 overlap
    add_token(ModeSpare, 8'h7F, 15'h7FFF, 4'hF);       // dropped
    add_token(ModeMatch, 8'h00, 15'h2AAA, 4'd10);
    add_token(ModeMatch, 8'h00, 15'h5555, 4'd5);
    add_token(ModeLit, 8'h96, 15'd0, 4'd0);
    add_token(ModeMatch, 8'h00, 15'd30, 4'd15);
    wait_drained();

    // limit five bytes ahead: copy cut short, then a silent copy and literal
    write_size(produced + 32'd5);
    add_token(ModeLit, 8'h11, 15'd0, 4'd0);
    add_token(ModeLit, 8'h22, 15'd0, 4'd0);
    add_token(ModeMatch, 8'h00, 15'd2, 4'd15);
    add_token(ModeMatch, 8'h00, 15'd1, 4'd0);
    add_token(ModeLit, 8'h33, 15'd0, 4'd0);
    wait_drained();

    // random, sender idles less than receiver
    write_size(32'hFFFF_FFFF);
    fill_random(100);
    wait_drained();

    // random, roles swapped; limit lands midway
    send_gap_pct = 74;
    pop_gap_pct  = 32;
    write_size(produced + 32'd400);
    fill_random(100);
    wait_drained();

    // no idling: a run of long copies back to back, then random traffic
    send_gap_pct = 0;
    pop_gap_pct  = 0;
    write_size(32'hFFFF_FFFF);
    repeat (60) begin
      if ($urandom_range(19) == 0) add_token(ModeLit, DataW'($urandom), 15'd0, 4'd0);
      else add_token(ModeMatch, DataW'($urandom), DistW'($urandom), 4'd15);
    end
    fill_random(100);
    wait_drained();

    // end mark with the limit already reached, then tokens after the end
    write_size(produced);
    add_token(ModeLit, 8'h44, 15'd0, 4'd0);
    add_token(ModeEnd, DataW'($urandom), DistW'($urandom), CodeW'($urandom));
    add_token(ModeLit, 8'h55, 15'd0, 4'd0);
    add_token(ModeMatch, 8'h00, 15'd1, 4'd15);
    add_token(ModeEnd, 8'h00, 15'd0, 4'd0);
    add_token(ModeSpare, 8'h00, 15'd0, 4'd0);
    wait_drained();

    $display("%0d tokens taken, %0d results checked, %0d bytes decoded (window %s)",
             tokens_taken, results_seen, produced,
             (produced >= WinDepth) ? "wrapped" : "not wrapped");
    $display("limits 0, max and partial; end mark seen %b; %0d mismatches",
             halted, err_cnt);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
